// ----- sv/positional_list_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Wraps concurrent assertions so that synthesis sees empty text.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that cons holds in every cycle in which ante holds.
`define PLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional_list_engine: assertion failed");

// Checks that prop holds in every cycle.
`define PLE_ASSERT_ALWAYS(label, clk, rst, prop) \
   `PLE_ASSERT_IMPLY(label, clk, rst, 1'b1, prop)

`else

`define PLE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PLE_ASSERT_ALWAYS(label, clk, rst, prop)

`endif

`endif

// ----- sv/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Command codes, status codes, fixed field widths and the sequencer states.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CMD_W       = 4;
   localparam int POS_W       = 16;
   localparam int XDATA_W     = 32;
   localparam int COUNT_OUT_W = 9;
   localparam int STATUS_W    = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd4;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 4'd5;
   localparam logic [CMD_W-1:0] CMD_READ_AT    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_FRONT      = 4'd7;
   localparam logic [CMD_W-1:0] CMD_BACK       = 4'd8;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_RDWAIT,
      ST_FINISH
   } state_type;

endpackage

// ----- sv/ple_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list with end and positional access, kept in one RAM.
// ----------------------------------------------------------------------------
// Each command beat on the req_ channel (req_valid/req_ready) carries a
// command, a signed position and a data word; every command produces exactly
// one result beat on the rsp_ channel (rsp_valid/rsp_ready) with the read
// data, a found flag, the element count, an empty flag and a status code.
// The block works on one command at a time and is not ready while it works.
// Push back, pop back, clear and other commands that move no entries go
// straight to the finish state; reads that hit an entry pass through a wait
// state for the RAM's registered read data. A positional insert or push front
// moves the entries behind the position up one place, one entry per cycle
// through the RAM's read and write ports, and then writes the new entry in a
// place state; an erase or pop front moves the entries behind it down. The RAM
// ports set that pace: one entry is read and one written per cycle. The
// longest command is an insert at the head of a list one entry short of
// full. A new command is taken in the cycle after the result is loaded into
// the output register.
// Reset empties the list at once (the element count goes to zero); the
// element RAM is not cleared, as entries at or beyond the count are never
// read. If the receiver stalls, the result is held in the output register;
// the next command may be taken and worked on, and it waits at its end
// until the output register is free.
// ----------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [CMD_W-1:0]             req_cmd,
   input  logic signed [POS_W-1:0]      req_position,
   input  logic [XDATA_W-1:0]           req_data_in,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [XDATA_W-1:0]           rsp_data_out,
   output logic                         rsp_found,
   output logic [COUNT_OUT_W-1:0]       rsp_element_count,
   output logic                         rsp_is_empty,
   output logic [STATUS_W-1:0]          rsp_status
);

   // Address width of the element RAM, width of the element count, and a
   // signed width wide enough to compare the position against the count.
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = ((CW > POS_W) ? CW : POS_W) + 2;

   // Sequencer and list state.
   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          cursor_ff, cursor_in;
   logic [AW-1:0]          end_ff, end_in;
   logic                   dir_up_ff, dir_up_in;
   logic [DATA_WIDTH-1:0]  hold_data_ff, hold_data_in;

   // Result waiting to be moved into the output register.
   logic [XDATA_W-1:0]     pend_data_ff, pend_data_in;
   logic                   pend_found_ff, pend_found_in;
   logic [STATUS_W-1:0]    pend_status_ff, pend_status_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [XDATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // Element RAM ports.
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [DATA_WIDTH-1:0]  ram_wdata;
   logic [AW-1:0]          ram_raddr;
   logic [DATA_WIDTH-1:0]  ram_rdata;

   // Command decode, valid in the idle state.
   logic                   accept;
   logic                   list_full;
   logic                   list_empty;
   logic signed [SW-1:0]   pos_ext;
   logic signed [SW-1:0]   cnt_ext;
   logic signed [SW-1:0]   cnt_m1_ext;
   logic [AW-1:0]          pos_idx;
   logic [AW-1:0]          last_idx;
   logic [CW-1:0]          ins_at;
   logic                   ins_append;
   logic [AW-1:0]          rm_at;
   logic                   rm_last;
   logic                   read_out_of_range;
   logic                   out_free;

   // Shared step unit: the cursor walks one entry per cycle, and the
   // entry read last cycle is written to its neighbor on the other side.
   logic [AW-1:0]          step_fwd;
   logic [AW-1:0]          step_back;
   logic                   shift_done;

   ple_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------------------
   // Decode of the command at the input.
   // ------------------------------------------------------------------------
   always_comb begin
      accept      = req_valid && (state_ff == ST_IDLE);
      list_full   = (count_ff == CW'(CAPACITY));
      list_empty  = (count_ff == '0);
      pos_ext     = SW'(req_position);
      cnt_ext     = signed'(SW'(count_ff));
      cnt_m1_ext  = cnt_ext - SW'(1);
      pos_idx     = pos_ext[AW-1:0];
      last_idx    = AW'(count_ff - CW'(1));
      out_free    = !rsp_valid_ff || rsp_ready;

      // Insert index: clamped to the range 0 .. count.
      if (req_cmd == CMD_PUSH_BACK) begin
         ins_at = count_ff;
      end else if (req_cmd == CMD_PUSH_FRONT) begin
         ins_at = '0;
      end else if (pos_ext >= cnt_ext) begin
         ins_at = count_ff;
      end else if (pos_ext <= 0) begin
         ins_at = '0;
      end else begin
         ins_at = CW'(pos_idx);
      end
      ins_append = (ins_at == count_ff);

      // Erase index: clamped to the range 0 .. count-1.
      if (req_cmd == CMD_POP_FRONT) begin
         rm_at = '0;
      end else if (req_cmd == CMD_POP_BACK) begin
         rm_at = last_idx;
      end else if (pos_ext >= cnt_m1_ext) begin
         rm_at = last_idx;
      end else if (pos_ext <= 0) begin
         rm_at = '0;
      end else begin
         rm_at = pos_idx;
      end
      rm_last = (rm_at == last_idx);

      read_out_of_range = (pos_ext < 0) || (pos_ext >= cnt_ext);

      step_fwd   = dir_up_ff ? (cursor_ff - AW'(1)) : (cursor_ff + AW'(1));
      step_back  = dir_up_ff ? (cursor_ff + AW'(1)) : (cursor_ff - AW'(1));
      shift_done = (cursor_ff == end_ff);
   end

   // ------------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FINISH;
               case (req_cmd)
                  CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
                     if (!list_full && !ins_append) begin
                        state_in = ST_SHIFT;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
                     if (!list_empty && !rm_last) begin
                        state_in = ST_SHIFT;
                     end
                  end
                  CMD_READ_AT: begin
                     if (!list_empty && !read_out_of_range) begin
                        state_in = ST_RDWAIT;
                     end
                  end
                  CMD_FRONT, CMD_BACK: begin
                     if (!list_empty) begin
                        state_in = ST_RDWAIT;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (shift_done) begin
               state_in = dir_up_ff ? ST_PLACE : ST_FINISH;
            end
         end
         ST_PLACE: begin
            state_in = ST_FINISH;
         end
         ST_RDWAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath control and register next values.
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      count_in       = count_ff;
      cursor_in      = cursor_ff;
      end_in         = end_ff;
      dir_up_in      = dir_up_ff;
      hold_data_in   = hold_data_ff;
      pend_data_in   = pend_data_ff;
      pend_found_in  = pend_found_ff;
      pend_status_in = pend_status_ff;
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = '0;
      ram_raddr      = '0;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_data_in   = '0;
               pend_found_in  = 1'b0;
               pend_status_in = STATUS_OK;
               hold_data_in   = DATA_WIDTH'(req_data_in);
               case (req_cmd)
                  CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
                     if (list_full) begin
                        pend_status_in = STATUS_FULL;
                     end else if (ins_append) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(count_ff);
                        ram_wdata = DATA_WIDTH'(req_data_in);
                        count_in  = count_ff + CW'(1);
                     end else begin
                        // Move entries up, starting at the last one.
                        ram_raddr = last_idx;
                        cursor_in = last_idx;
                        end_in    = AW'(ins_at);
                        dir_up_in = 1'b1;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
                     if (list_empty) begin
                        pend_status_in = STATUS_NONE;
                     end else if (rm_last) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        // Move entries down, starting just past the hole.
                        ram_raddr = rm_at + AW'(1);
                        cursor_in = rm_at + AW'(1);
                        end_in    = last_idx;
                        dir_up_in = 1'b0;
                     end
                  end
                  CMD_READ_AT: begin
                     if (list_empty || read_out_of_range) begin
                        pend_status_in = STATUS_NONE;
                     end else begin
                        ram_raddr = pos_idx;
                     end
                  end
                  CMD_FRONT: begin
                     if (list_empty) begin
                        pend_status_in = STATUS_NONE;
                     end else begin
                        ram_raddr = '0;
                     end
                  end
                  CMD_BACK: begin
                     if (list_empty) begin
                        pend_status_in = STATUS_NONE;
                     end else begin
                        ram_raddr = last_idx;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     pend_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // The entry read last cycle goes to its neighbor; the next
            // entry is read unless the walk has reached its end.
            ram_we    = 1'b1;
            ram_waddr = step_back;
            ram_wdata = ram_rdata;
            if (shift_done) begin
               if (!dir_up_ff) begin
                  count_in = count_ff - CW'(1);
               end
            end else begin
               ram_raddr = step_fwd;
               cursor_in = step_fwd;
            end
         end
         ST_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = end_ff;
            ram_wdata = hold_data_ff;
            count_in  = count_ff + CW'(1);
         end
         ST_RDWAIT: begin
            pend_data_in  = XDATA_W'(ram_rdata);
            pend_found_in = 1'b1;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pend_data_ff;
               rsp_found_in  = pend_found_ff;
               rsp_count_in  = COUNT_OUT_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               rsp_status_in = pend_status_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff      <= cursor_in;
      end_ff         <= end_in;
      dir_up_ff      <= dir_up_in;
      hold_data_ff   <= hold_data_in;
      pend_data_ff   <= pend_data_in;
      pend_found_ff  <= pend_found_in;
      pend_status_ff <= pend_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_status        = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // The element count never passes the capacity.
   `PLE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))

   // A found element is always reported with an ok status.
   `PLE_ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid_ff && rsp_found_ff, rsp_status_ff == STATUS_OK)

   // An upward walk never passes below its target, a downward one never above.
   `PLE_ASSERT_IMPLY(a_walk_up, clock, reset, (state_ff == ST_SHIFT) && dir_up_ff, cursor_ff >= end_ff)
   `PLE_ASSERT_IMPLY(a_walk_down, clock, reset, (state_ff == ST_SHIFT) && !dir_up_ff, cursor_ff <= end_ff)

endmodule
